// ===== src/bfba_pkg.sv =====
// Shared constants, types and status codes for the best-fit bin allocator.
package bfba_pkg;

	localparam int MAX_BINS  = 64;
	localparam int SIZE_BITS = 16;
	localparam int IDX_BITS  = $clog2(MAX_BINS);
	localparam int CNT_BITS  = $clog2(MAX_BINS + 1);

	localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_BINS);

	localparam logic [1:0] ST_PLACED   = 2'd0;
	localparam logic [1:0] ST_OVERSIZE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic                 re;
		logic [IDX_BITS-1:0]  raddr;
		logic                 we;
		logic [IDX_BITS-1:0]  waddr;
		logic [SIZE_BITS-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] bin_index;
		logic                opened_new;
		logic [CNT_BITS-1:0] bins_used;
		logic [1:0]          status;
		logic                set_done;
	} res_t;

endpackage

// ===== src/bfba_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module bfba_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bfba_scan.sv =====
// Scan sequencer: reads every open bin, tracks the best fit, writes back the chosen bin.
module bfba_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bfba_pkg::SIZE_BITS-1:0]   in_size,
	input  logic                             in_last,
	input  logic [bfba_pkg::SIZE_BITS-1:0]   capacity,
	output bfba_pkg::ram_req_t               ram_req,
	input  logic [bfba_pkg::SIZE_BITS-1:0]   ram_rdata,
	output logic                             res_valid,
	input  logic                             res_ready,
	output bfba_pkg::res_t                   res
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DRAIN  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]                         state_q;
	logic [bfba_pkg::CNT_BITS-1:0]      open_q;
	logic [bfba_pkg::CNT_BITS-1:0]      rd_idx_q;
	logic                               v_s1;
	logic [bfba_pkg::IDX_BITS-1:0]      idx_s1;
	logic                               found_q;
	logic [bfba_pkg::IDX_BITS-1:0]      best_idx_q;
	logic [bfba_pkg::SIZE_BITS-1:0]     best_left_q;
	logic [bfba_pkg::SIZE_BITS-1:0]     size_q;
	logic                               last_q;
	bfba_pkg::res_t                     res_q;

	logic                               fits;
	logic [bfba_pkg::SIZE_BITS-1:0]     left;
	logic                               take;
	logic                               room;
	logic [bfba_pkg::CNT_BITS-1:0]      new_cnt;
	logic [bfba_pkg::CNT_BITS-1:0]      rd_idx_nxt;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res       = res_q;

	// Compare stage works on the word read in the previous cycle.
	assign fits = (ram_rdata >= size_q);
	assign left = ram_rdata - size_q;
	assign take = v_s1 && fits && (!found_q || (left < best_left_q));

	assign room       = (open_q != bfba_pkg::MAX_CNT);
	assign new_cnt    = (!found_q && room) ? open_q + bfba_pkg::CNT_BITS'(1) : open_q;
	assign rd_idx_nxt = rd_idx_q + bfba_pkg::CNT_BITS'(1);

	always_comb begin
		ram_req.re    = (state_q == S_SCAN);
		ram_req.raddr = rd_idx_q[bfba_pkg::IDX_BITS-1:0];
		ram_req.we    = (state_q == S_DECIDE) && (found_q || room);
		ram_req.waddr = found_q ? best_idx_q : open_q[bfba_pkg::IDX_BITS-1:0];
		ram_req.wdata = found_q ? best_left_q : capacity - size_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			open_q   <= '0;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_SCAN);
			if (take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						found_q  <= 1'b0;
						rd_idx_q <= '0;
						if (in_size > capacity) begin
							state_q <= S_FINISH;
							if (in_last) begin
								open_q <= '0;
							end
						end else if (open_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_nxt;
					if (rd_idx_nxt == open_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					open_q  <= last_q ? '0 : new_cnt;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[bfba_pkg::IDX_BITS-1:0];
		if (take) begin
			best_idx_q  <= idx_s1;
			best_left_q <= left;
		end
		if (in_valid && in_ready) begin
			size_q <= in_size;
			last_q <= in_last;
			res_q  <= '{bin_index: '0, opened_new: 1'b0, bins_used: open_q,
				status: bfba_pkg::ST_OVERSIZE, set_done: in_last};
		end
		if (state_q == S_DECIDE) begin
			res_q.bins_used <= new_cnt;
			if (found_q) begin
				res_q.bin_index  <= best_idx_q;
				res_q.opened_new <= 1'b0;
				res_q.status     <= bfba_pkg::ST_PLACED;
			end else if (room) begin
				res_q.bin_index  <= open_q[bfba_pkg::IDX_BITS-1:0];
				res_q.opened_new <= 1'b1;
				res_q.status     <= bfba_pkg::ST_PLACED;
			end else begin
				res_q.bin_index  <= '0;
				res_q.opened_new <= 1'b0;
				res_q.status     <= bfba_pkg::ST_FULL;
			end
		end
	end

endmodule

// ===== src/best_fit_bin_allocator.sv =====
// Top level of the best-fit bin allocator: ports, capacity register, bin memory, output register.
// An accepted word passes through the scan states SCAN, DRAIN, DECIDE and FINISH and then the output
// register; with no open bin it skips SCAN and DRAIN, and an oversized item goes straight to FINISH.
// A new item is taken only after the previous one has left FINISH; the bin memory is read one
// entry per cycle by the scan.
// Reset (arst_n low, asynchronous) closes all bins and sets the capacity to 65535.
module best_fit_bin_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] item_size
	input  logic        s_tlast,   // last_item
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [5:0] bin_index, [6] opened_new, [13:7] bins_used,
	                               // [15:14] status
	output logic        m_tlast,   // set_done
	// Capacity register write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [bfba_pkg::SIZE_BITS-1:0] cap_q;
	bfba_pkg::ram_req_t             ram_req;
	logic [bfba_pkg::SIZE_BITS-1:0] ram_rdata;
	logic                           res_valid;
	logic                           res_ready;
	bfba_pkg::res_t                 res;
	logic                           m_tvalid_q;
	bfba_pkg::res_t                 out_q;

	// The capacity register is always writable; the user must change configuration only while idle.
	// The block does not enforce this, and a new value affects only bins opened afterwards.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Remaining space of each bin. Entries above the open-bin count are never read, so the memory
	// needs neither clearing nor valid bits.
	bfba_ram #(
		.DEPTH(bfba_pkg::MAX_BINS),
		.WIDTH(bfba_pkg::SIZE_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	// The scan sequencer takes a word only while no other item is in flight, and the write-back
	// happens before the next item can begin its reads, so reads never overlap a pending write.
	bfba_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_size  (s_tdata),
		.in_last  (s_tlast),
		.capacity (cap_q),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Output register. It decouples the master side, so the next item can be accepted and scanned
	// while the previous result still waits for m_tready.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_q.status, out_q.bins_used, out_q.opened_new, out_q.bin_index};
	assign m_tlast  = out_q.set_done;

endmodule

// ===== src/bfba_checker.sv =====
// Port-level checker for the best-fit bin allocator, bound to the top level.
module bfba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result keeps its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Only defined status codes are reported.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:14] == bfba_pkg::ST_PLACED) ||
			(m_tdata[15:14] == bfba_pkg::ST_OVERSIZE) ||
			(m_tdata[15:14] == bfba_pkg::ST_FULL))
		else $error("undefined status code");

	// A newly opened bin means the item was placed.
	a_open_placed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> m_tdata[15:14] == bfba_pkg::ST_PLACED)
		else $error("new bin reported for a rejected item");

	// A placed item sits in a bin below the open-bin count.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15:14] == bfba_pkg::ST_PLACED |->
			m_tdata[13:7] > {1'b0, m_tdata[5:0]})
		else $error("bin index not below bins used");

	// The bin count never exceeds the table size.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:7] <= bfba_pkg::MAX_CNT)
		else $error("bins used above table size");

endmodule

bind best_fit_bin_allocator bfba_checker u_bfba_checker (.*);

// ===== tb/best_fit_bin_allocator_tb.sv =====
// Self-checking testbench for the best-fit bin allocator: streamed items, predicted placements.
module best_fit_bin_allocator_tb;

	import bfba_pkg::*;

	// One item waiting to go out on the slave side.
	typedef struct {
		logic [SIZE_BITS-1:0] size;
		logic                 last;
	} bin_item_t;

	// Clock, reset and every block input start at a known value.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;   // [15:0] item_size
	logic        s_tlast   = 1'b0; // last_item
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // [5:0] bin_index, [6] opened_new, [13:7] bins_used,
	                               // [15:14] status
	logic        m_tlast;          // set_done
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	// Items the driver still has to hand over, and placements not yet seen on the master side.
	bin_item_t items_to_send[$];
	res_t      placements_due[$];

	// Shadow of the block: the capacity register, the space left per bin and the open bin count.
	logic [SIZE_BITS-1:0] capacity = 16'hFFFF;
	logic [SIZE_BITS-1:0] bin_space [MAX_BINS];
	logic [CNT_BITS-1:0]  open_cnt = '0;

	// Idle and stall rates in percent, changed by the stimulus between phases.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int err_count     = 0;

	best_fit_bin_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Best-fit placement of one item against the shadow table. The scan keeps the first bin
	// with the smallest leftover, so ties resolve to the lowest index. When nothing fits, a new
	// bin is opened with the current capacity, unless the table is already full. The reported
	// count is taken before a last item clears the table, even for a rejected item.
	function automatic res_t place_item(logic [SIZE_BITS-1:0] size, logic last);
		res_t                 r;
		logic                 found;
		logic [IDX_BITS-1:0]  best;
		logic [SIZE_BITS-1:0] best_left;
		r         = '0;
		r.set_done = last;
		found     = 1'b0;
		best      = '0;
		best_left = '0;
		if (size > capacity) begin
			r.status = ST_OVERSIZE;
		end else begin
			for (int j = 0; j < open_cnt; j++) begin
				if (bin_space[j] >= size && (!found || bin_space[j] - size < best_left)) begin
					found     = 1'b1;
					best      = IDX_BITS'(j);
					best_left = bin_space[j] - size;
				end
			end
			if (found) begin
				bin_space[best] = best_left;
				r.bin_index     = best;
			end else if (open_cnt < MAX_CNT) begin
				bin_space[open_cnt[IDX_BITS-1:0]] = capacity - size;
				r.bin_index  = open_cnt[IDX_BITS-1:0];
				r.opened_new = 1'b1;
				open_cnt     = open_cnt + 1'b1;
			end else begin
				r.status = ST_FULL;
			end
		end
		r.bins_used = open_cnt;
		if (last)
			open_cnt = '0;
		return r;
	endfunction

	// Driver. The word on the bus is the head of the queue; it leaves the queue at the edge where
	// it is accepted, and its placement is predicted right then. A new word is offered only when
	// the bus is free, so tvalid gets one assignment per edge and never drops under a held word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				placements_due.push_back(place_item(items_to_send[0].size, items_to_send[0].last));
				void'(items_to_send.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= items_to_send[0].size;
					s_tlast  <= items_to_send[0].last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic note_mismatch(string field, int want, int got);
		err_count++;
		if (err_count <= 10)
			$display("MISMATCH %s: expected %0d, got %0d", field, want, got);
	endtask

	// Monitor. It throttles tready at random and checks every accepted result word, field by
	// field, against the oldest predicted placement.
	always @(posedge clk) begin : monitor
		res_t want;
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (placements_due.size() == 0) begin
				note_mismatch("unexpected result word, data", 0, m_tdata);
			end else begin
				want = placements_due.pop_front();
				if (m_tdata[5:0] !== want.bin_index)
					note_mismatch("bin_index", want.bin_index, m_tdata[5:0]);
				if (m_tdata[6] !== want.opened_new)
					note_mismatch("opened_new", want.opened_new, m_tdata[6]);
				if (m_tdata[13:7] !== want.bins_used)
					note_mismatch("bins_used", want.bins_used, m_tdata[13:7]);
				if (m_tdata[15:14] !== want.status)
					note_mismatch("status", want.status, m_tdata[15:14]);
				if (m_tlast !== want.set_done)
					note_mismatch("set_done", want.set_done, m_tlast);
			end
		end
	end

	task automatic push_item(int size, logic last);
		bin_item_t it;
		it.size = SIZE_BITS'(size);
		it.last = last;
		items_to_send.push_back(it);
	endtask

	// Waits until every queued word has gone out and every placement has come back, then waits on
	// so that the block has finished its write-back before anything else happens.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (items_to_send.size() != 0 || s_tvalid || placements_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes the capacity register over its own handshake; only called while the block is idle.
	task automatic write_capacity(int value);
		cfg_data  <= 16'(value);
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		capacity  = 16'(value);
		cfg_valid <= 1'b0;
	endtask

	// Random sets of items. Most sets are short and draw sizes across the capacity with the
	// extremes and some oversized items mixed in. About a quarter are long runs of items larger
	// than half a bin, which open a bin each and drive the table into the full case. A chunk may
	// end in the middle of a set, so the next capacity write lands mid-set.
	task automatic queue_sets(int n_items, int cap);
		int made;
		int len;
		int size;
		logic fill;
		made = 0;
		while (made < n_items) begin
			fill = ($urandom_range(3) == 0);
			len  = fill ? $urandom_range(72, 60) : $urandom_range(12, 1);
			for (int i = 0; i < len && made < n_items; i++) begin
				if (fill) begin
					size = ($urandom_range(9) == 0) ? $urandom_range(cap) :
					       $urandom_range(cap, cap / 2 + 1);
				end else begin
					case ($urandom_range(9))
						0: size = 0;
						1: size = cap;
						2: size = (cap < 65535) ? $urandom_range(65535, cap + 1) : cap;
						3: size = $urandom_range(65535);
						default: size = $urandom_range(cap);
					endcase
				end
				push_item(size, i == len - 1);
				made++;
			end
		end
	endtask

	initial begin : stimulus
		int cap;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: zero-size items, a bin filled exactly, and every size bit set.
		push_item(0, 1'b0);
		push_item(65535, 1'b0);
		push_item(0, 1'b0);
		push_item(1, 1'b0);
		push_item(65534, 1'b0);
		push_item(65535, 1'b1);
		wait_idle();

		// Oversized item, a tie between two bins, a best fit that is not the lowest bin, and a
		// rejected item that still ends the set.
		write_capacity(100);
		push_item(101, 1'b0);
		push_item(60, 1'b0);
		push_item(60, 1'b0);
		push_item(40, 1'b0);
		push_item(70, 1'b0);
		push_item(20, 1'b0);
		push_item(200, 1'b1);
		wait_idle();

		// Zero capacity takes only zero-size items.
		write_capacity(0);
		push_item(0, 1'b0);
		push_item(1, 1'b0);
		push_item(0, 1'b1);
		wait_idle();

		// Capacity raised in the middle of a set: old bins keep their space.
		write_capacity(1000);
		push_item(900, 1'b0);
		push_item(900, 1'b0);
		wait_idle();
		write_capacity(2000);
		push_item(1500, 1'b0);
		push_item(90, 1'b0);
		push_item(65535, 1'b1);
		wait_idle();

		// Random part in four idling phases of two chunks each. The sender holds off between
		// chunks until every placement has come back, and the capacity changes there.
		for (int k = 0; k < 8; k++) begin
			case (k / 2)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 79; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 79; end
				default: begin send_idle_pct = 8; stall_pct = 8; end
			endcase
			if (k == 0)
				cap = 1;
			else if (k == 1)
				cap = 65535;
			else begin
				case ($urandom_range(3))
					0: cap = 65535;
					1: cap = $urandom_range(20, 1);
					2: cap = $urandom_range(65535, 1);
					default: cap = $urandom_range(1000, 100);
				endcase
			end
			write_capacity(cap);
			queue_sets(104, cap);
			wait_idle();
		end

		// Anything arriving now has no placement waiting and is flagged by the monitor.
		repeat (80) @(posedge clk);
		if (placements_due.size() != 0)
			err_count++;
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run.
	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
